>>> design/imuodb_pkg.sv
// Shared types and constants for the IMU offset and deadband filter.
`timescale 1ns / 1ps

package imuodb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 26;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [LEVEL_W-1:0]  level_t;

  // Per-item control that the sequencer hands to every axis datapath.
  typedef struct packed {
    logic en;
    logic cal_phase;
    logic first;
    logic group_end;
  } axis_ctrl_t;

endpackage

>>> design/imuodb_axis.sv
// Per-axis calibration sum, deadband tracking, group sum and level arithmetic.
`timescale 1ns / 1ps

module imuodb_axis #(
  parameter int CAL_SAMPLES = 50,
  parameter int AVG_SAMPLES = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imuodb_pkg::axis_ctrl_t ctrl,
  input  imuodb_pkg::sample_t  sample,
  output imuodb_pkg::level_t   level
);

  localparam int SW   = imuodb_pkg::SAMPLE_W;
  localparam int CW   = SW + $clog2(CAL_SAMPLES);
  localparam int GW   = SW + $clog2(AVG_SAMPLES);
  localparam int MW   = (CW > GW) ? CW : GW;
  localparam int PW   = (MW + 8 > imuodb_pkg::LEVEL_W + 1) ? MW + 8 : imuodb_pkg::LEVEL_W + 1;

  logic signed [CW-1:0] cal_sum_r, cal_sum_nxt;
  logic signed [GW-1:0] group_sum_r, group_sum_nxt;
  logic signed [SW-1:0] band_low_r, band_low_nxt;
  logic signed [SW-1:0] band_high_r, band_high_nxt;

  logic signed [SW-1:0] low_base;
  logic signed [SW-1:0] dead_val;
  logic signed [GW-1:0] group_acc;
  logic signed [PW-1:0] group_ext;
  logic signed [PW-1:0] cal_ext;
  logic signed [PW-1:0] level_full;

  always_comb begin
    low_base = ctrl.first ? sample : band_low_r;
    dead_val = ((sample < band_high_r) && (sample > band_low_r)) ? '0 : sample;
    group_acc = group_sum_r + {{(GW-SW){dead_val[SW-1]}}, dead_val};
    group_ext = {{(PW-GW){group_acc[GW-1]}}, group_acc};
    cal_ext   = {{(PW-CW){cal_sum_r[CW-1]}}, cal_sum_r};
    level_full = (group_ext * PW'(CAL_SAMPLES)) - (cal_ext * PW'(AVG_SAMPLES));
    level = level_full[imuodb_pkg::LEVEL_W-1:0];

    cal_sum_nxt   = cal_sum_r;
    band_low_nxt  = band_low_r;
    band_high_nxt = band_high_r;
    group_sum_nxt = group_sum_r;
    if (ctrl.en) begin
      if (ctrl.cal_phase) begin
        cal_sum_nxt  = cal_sum_r + {{(CW-SW){sample[SW-1]}}, sample};
        band_low_nxt = low_base;
        if (sample > band_high_r) begin
          band_high_nxt = sample;
        end else if (sample < low_base) begin
          band_low_nxt = sample;
        end
      end else begin
        group_sum_nxt = ctrl.group_end ? '0 : group_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_sum_r   <= '0;
      group_sum_r <= '0;
      band_low_r  <= '0;
      band_high_r <= '0;
    end else begin
      cal_sum_r   <= cal_sum_nxt;
      group_sum_r <= group_sum_nxt;
      band_low_r  <= band_low_nxt;
      band_high_r <= band_high_nxt;
    end
  end

endmodule

>>> design/imu_offset_deadband_filter_core.sv
// Top level of the three-axis IMU offset calibration and deadband averaging filter.
// Flow: an item enters the input register, and a group's result is loaded into the
// output register as the last item of the group leaves the input register, unless an
// earlier result is still waiting. Throughput: one item per cycle, set by the single
// accumulate pass per axis; a waiting result holds the item in the input register.
// Reset: synchronous rst_n clears the sequencer, the sums, the bands and both valids.
`timescale 1ns / 1ps

module imu_offset_deadband_filter_core #(
  parameter int CAL_SAMPLES = 50,
  parameter int AVG_SAMPLES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imuodb_pkg::sample_t in_sample_x,
  input  imuodb_pkg::sample_t in_sample_y,
  input  imuodb_pkg::sample_t in_sample_z,
  output logic                out_valid,
  input  logic                out_ready,
  output imuodb_pkg::level_t  out_level_x,
  output imuodb_pkg::level_t  out_level_y,
  output imuodb_pkg::level_t  out_level_z
);

  localparam int MAXN  = (CAL_SAMPLES > AVG_SAMPLES) ? CAL_SAMPLES : AVG_SAMPLES;
  localparam int CNT_W = $clog2(MAXN + 1);

  logic                s1_valid_r, s1_valid_nxt;
  imuodb_pkg::sample_t s1_x_r, s1_y_r, s1_z_r;
  logic                cal_r, cal_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  imuodb_pkg::level_t  out_x_r, out_y_r, out_z_r;

  logic                stall;
  logic                fire;
  logic                last;
  imuodb_pkg::axis_ctrl_t ctrl;
  imuodb_pkg::level_t  lvl_x, lvl_y, lvl_z;

  always_comb begin
    stall    = out_valid_r && !out_ready;
    in_ready = !s1_valid_r || !stall;
    fire     = s1_valid_r && !stall;
    last     = cal_r ? (cnt_r == CNT_W'(AVG_SAMPLES - 1)) : (cnt_r == CNT_W'(CAL_SAMPLES - 1));

    ctrl.en        = fire;
    ctrl.cal_phase = !cal_r;
    ctrl.first     = (cnt_r == '0);
    ctrl.group_end = cal_r && last;

    s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

    cal_nxt = cal_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (last) begin
        cnt_nxt = '0;
        cal_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (fire && ctrl.group_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      cal_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      cal_r       <= cal_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r <= in_sample_x;
      s1_y_r <= in_sample_y;
      s1_z_r <= in_sample_z;
    end
    if (fire && ctrl.group_end) begin
      out_x_r <= lvl_x;
      out_y_r <= lvl_y;
      out_z_r <= lvl_z;
    end
  end

  imuodb_axis #(.CAL_SAMPLES(CAL_SAMPLES), .AVG_SAMPLES(AVG_SAMPLES)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sample(s1_x_r), .level(lvl_x)
  );

  imuodb_axis #(.CAL_SAMPLES(CAL_SAMPLES), .AVG_SAMPLES(AVG_SAMPLES)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sample(s1_y_r), .level(lvl_y)
  );

  imuodb_axis #(.CAL_SAMPLES(CAL_SAMPLES), .AVG_SAMPLES(AVG_SAMPLES)) u_axis_z (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sample(s1_z_r), .level(lvl_z)
  );

  assign out_valid   = out_valid_r;
  assign out_level_x = out_x_r;
  assign out_level_y = out_y_r;
  assign out_level_z = out_z_r;

endmodule
